// ===== rtl/cover_crop_nearest_scaler_unit_assert.svh =====
// Assertion macros shared by the scaler modules
`ifndef COVER_CROP_NEAREST_SCALER_UNIT_ASSERT_SVH
`define COVER_CROP_NEAREST_SCALER_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define CCNS_ASSERT_IMPLY(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("scaler check failed");

// next-cycle implication, disabled during reset
`define CCNS_ASSERT_NEXT(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("scaler check failed");

`endif

// ===== rtl/ccns_pkg.sv =====
// Shared constants and types of the cover-crop nearest scaler
package ccns_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int ADDR_W     = COL_W + ROW_W;
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int DIM_W      = 9;
  localparam int CR_MAX     = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int CRD_W      = (CR_MAX > DIM_W) ? CR_MAX : DIM_W;
  localparam int BYTE_W     = 8;
  localparam int PIX_W      = 3 * BYTE_W;
  localparam int NUM_W      = 18;
  localparam int DIV_W      = DIM_W + 1;
  localparam int IDX_W      = 2;
  localparam int IN_W       = 5 * BYTE_W;

  localparam int QDEPTH     = 32;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_DST_WIDTH     = 2'd2;
  localparam logic [IDX_W-1:0] REG_DST_HEIGHT    = 2'd3;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_READ,
    OP_RANGE
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  pix;
  } entry_t;

endpackage

// ===== rtl/cover_crop_nearest_scaler_unit.sv =====
// A fetch beat passes the settle delay, quotient pipeline, queue and a memory read.
// Throughput: one beat per cycle, paced by the 18-stage quotient pipeline and one
// frame memory port; the queue credit stalls input only when the back end is held.
// Store beats give no result; in-frame stores write the frame memory in beat order.
// Reset: synchronous, clears control state and restores default geometry; the frame
// memory is not cleared.
module cover_crop_nearest_scaler_unit import ccns_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // column, row, byte_first, byte_middle, byte_last
  input  logic             s_tuser,   // kind
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [PIX_W-1:0] m_tdata,   // out_first, out_middle, out_last
  output logic             m_tuser,   // out_of_range
  input  logic             cfg_wen,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0] cfg_data
);

  logic              push, pop, head_valid;
  entry_t            push_entry, head_entry;
  logic [QCNT_W-1:0] q_count;

  ccns_front u_front (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .q_count(q_count), .q_push(push), .q_entry(push_entry)
  );

  ccns_queue u_queue (
    .clk(clk), .rst(rst),
    .push(push), .push_entry(push_entry), .pop(pop),
    .head_valid(head_valid), .head_entry(head_entry), .count(q_count)
  );

  ccns_back u_back (
    .clk(clk), .rst(rst),
    .q_valid(head_valid), .q_entry(head_entry), .q_pop(pop),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

endmodule

// ===== rtl/ccns_div.sv =====
// Pipelined restoring divider, one quotient bit per stage
module ccns_div import ccns_pkg::*; (
  input  logic             clk,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic [NUM_W-1:0] quotient
);

  logic [DIV_W-1:0] rem [NUM_W-1];
  logic [NUM_W-1:0] dvd [NUM_W];

  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic [DIV_W-1:0] rem_in;
    logic [NUM_W-1:0] dvd_in;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic             qbit;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign dvd_in = dividend;
    end else begin : g_next
      assign rem_in = rem[i-1];
      assign dvd_in = dvd[i-1];
    end

    assign trial = {rem_in, dvd_in[NUM_W-1]};
    assign diff  = trial - {1'b0, divisor};
    assign qbit  = (trial >= {1'b0, divisor});

    always_ff @(posedge clk) begin
      dvd[i] <= {dvd_in[NUM_W-2:0], qbit};
    end

    if (i < NUM_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        rem[i] <= qbit ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      end
    end
  end

  assign quotient = dvd[NUM_W-1];

endmodule

// ===== rtl/ccns_front.sv =====
// Front end: configuration, beat classification and coordinate mapping
module ccns_front import ccns_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_W-1:0]   s_tdata,
  input  logic              s_tuser,
  input  logic              cfg_wen,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [DIM_W-1:0]  cfg_data,
  input  logic [QCNT_W-1:0] q_count,
  output logic              q_push,
  output entry_t            q_entry
);

  localparam int DELAY = 4;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] col;
    logic [BYTE_W-1:0] row;
    logic [PIX_W-1:0]  pix;
  } item_t;

  typedef struct packed {
    logic              valid;
    logic              keep;
    op_t               op;
    logic [BYTE_W-1:0] col;
    logic [BYTE_W-1:0] row;
    logic [PIX_W-1:0]  pix;
  } side_t;

  function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v, input int maxv);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (int'(v) > maxv) r = DIM_W'(maxv);
    return r;
  endfunction

  logic [DIM_W-1:0] source_width, source_height, dst_width, dst_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= DIM_W'(256);
      source_height <= DIM_W'(256);
      dst_width     <= '0;
      dst_height    <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_SOURCE_WIDTH:  source_width  <= cfg_data;
        REG_SOURCE_HEIGHT: source_height <= cfg_data;
        REG_DST_WIDTH:     dst_width     <= cfg_data;
        REG_DST_HEIGHT:    dst_height    <= cfg_data;
      endcase
    end
  end

  // geometry derived from the registers, four register levels deep
  logic [DIM_W-1:0] sw1, sh1, tw1, th1;
  logic [NUM_W-1:0] pa1, pb1;
  logic [DIM_W-1:0] sw2, sh2, tw2, th2, num2, den2;
  logic             id2;
  logic [DIM_W-1:0] sw3, sh3, tw3, th3, num3, den3;
  logic             id3;
  logic [NUM_W-1:0] bx3, cx3, by3, cy3;
  logic [DIM_W-1:0] sw4, sh4, twe4, the4, den4;
  logic             id4;
  logic [DIV_W-1:0] div4;
  logic [NUM_W-1:0] offx4, offy4;
  logic [DIM_W-1:0] sat_w, sat_h;

  assign sat_w = sat_dim(source_width, MAX_WIDTH);
  assign sat_h = sat_dim(source_height, MAX_HEIGHT);

  always_ff @(posedge clk) begin
    sw1  <= sat_w;
    sh1  <= sat_h;
    tw1  <= dst_width;
    th1  <= dst_height;
    pa1  <= NUM_W'(dst_width * sat_h);
    pb1  <= NUM_W'(dst_height * sat_w);

    sw2  <= sw1;
    sh2  <= sh1;
    tw2  <= tw1;
    th2  <= th1;
    id2  <= (tw1 == '0) || (th1 == '0) || ((tw1 == sw1) && (th1 == sh1));
    num2 <= (pa1 >= pb1) ? tw1 : th1;
    den2 <= (pa1 >= pb1) ? sw1 : sh1;

    sw3  <= sw2;
    sh3  <= sh2;
    tw3  <= tw2;
    th3  <= th2;
    id3  <= id2;
    num3 <= num2;
    den3 <= den2;
    bx3  <= NUM_W'(sw2 * num2);
    cx3  <= NUM_W'(tw2 * den2);
    by3  <= NUM_W'(sh2 * num2);
    cy3  <= NUM_W'(th2 * den2);

    sw4   <= sw3;
    sh4   <= sh3;
    id4   <= id3;
    den4  <= den3;
    twe4  <= id3 ? sw3 : tw3;
    the4  <= id3 ? sh3 : th3;
    div4  <= {num3, 1'b0};
    offx4 <= ((cx3 > bx3) ? '0 : bx3 - cx3) + NUM_W'(den3);
    offy4 <= ((cy3 > by3) ? '0 : by3 - cy3) + NUM_W'(den3);
  end

  // credit towards the queue
  logic              accept;
  logic              leave;
  logic [QCNT_W-1:0] inflight;
  logic [QCNT_W:0]   credit_sum;

  assign accept     = s_tvalid && s_tready;
  assign credit_sum = {1'b0, inflight} + {1'b0, q_count};
  assign s_tready   = (credit_sum < (QCNT_W+1)'(QDEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + QCNT_W'(accept) - QCNT_W'(leave);
    end
  end

  // hold beats until the geometry has settled
  logic  dly_valid [DELAY];
  item_t dly_item  [DELAY];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DELAY; i++) dly_valid[i] <= 1'b0;
    end else begin
      dly_valid[0] <= accept;
      for (int i = 1; i < DELAY; i++) dly_valid[i] <= dly_valid[i-1];
    end
  end

  always_ff @(posedge clk) begin
    dly_item[0] <= '{kind: s_tuser, col: s_tdata[7:0], row: s_tdata[15:8],
                     pix: {s_tdata[23:16], s_tdata[31:24], s_tdata[39:32]}};
    for (int i = 1; i < DELAY; i++) dly_item[i] <= dly_item[i-1];
  end

  // classify and form the dividends
  item_t             ci;
  side_t             c_side;
  logic [NUM_W-1:0]  c_numx, c_numy;
  logic [NUM_W-2:0]  c_prodx, c_prody;
  logic              c_oor, c_wr_ok;

  assign ci      = dly_item[DELAY-1];
  assign c_oor   = ({1'b0, ci.col} >= twe4) || ({1'b0, ci.row} >= the4);
  assign c_wr_ok = ({1'b0, ci.col} < sw4) && ({1'b0, ci.row} < sh4);
  assign c_prodx = (NUM_W-1)'(ci.col) * (NUM_W-1)'(den4);
  assign c_prody = (NUM_W-1)'(ci.row) * (NUM_W-1)'(den4);

  always_ff @(posedge clk) begin
    if (rst) begin
      c_side.valid <= 1'b0;
    end else begin
      c_side.valid <= dly_valid[DELAY-1];
    end
    c_side.keep <= ci.kind || c_wr_ok;
    priority if (!ci.kind) c_side.op <= OP_WRITE;
    else if (c_oor)        c_side.op <= OP_RANGE;
    else                   c_side.op <= OP_READ;
    c_side.col <= ci.col;
    c_side.row <= ci.row;
    c_side.pix <= ci.pix;
    c_numx <= offx4 + {c_prodx, 1'b0};
    c_numy <= offy4 + {c_prody, 1'b0};
  end

  logic [NUM_W-1:0] qx, qy;

  ccns_div u_div_x (.clk(clk), .dividend(c_numx), .divisor(div4), .quotient(qx));
  ccns_div u_div_y (.clk(clk), .dividend(c_numy), .divisor(div4), .quotient(qy));

  side_t sb [NUM_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_W; i++) sb[i].valid <= 1'b0;
    end else begin
      sb[0].valid <= c_side.valid;
      for (int i = 1; i < NUM_W; i++) sb[i].valid <= sb[i-1].valid;
    end
    sb[0].keep <= c_side.keep;
    sb[0].op   <= c_side.op;
    sb[0].col  <= c_side.col;
    sb[0].row  <= c_side.row;
    sb[0].pix  <= c_side.pix;
    for (int i = 1; i < NUM_W; i++) begin
      sb[i].keep <= sb[i-1].keep;
      sb[i].op   <= sb[i-1].op;
      sb[i].col  <= sb[i-1].col;
      sb[i].row  <= sb[i-1].row;
      sb[i].pix  <= sb[i-1].pix;
    end
  end

  // clamp, select and address
  side_t            ls;
  logic [DIM_W-1:0] smx, smy, cxq, cyq;
  logic [CRD_W-1:0] sx, sy;
  logic             f_valid, f_keep;
  entry_t           f_entry;

  assign ls  = sb[NUM_W-1];
  assign smx = sw4 - DIM_W'(1);
  assign smy = sh4 - DIM_W'(1);
  assign cxq = (qx > NUM_W'(smx)) ? smx : qx[DIM_W-1:0];
  assign cyq = (qy > NUM_W'(smy)) ? smy : qy[DIM_W-1:0];

  always_comb begin
    if (ls.op == OP_WRITE || id4) begin
      sx = CRD_W'(ls.col);
      sy = CRD_W'(ls.row);
    end else begin
      sx = CRD_W'(cxq);
      sy = CRD_W'(cyq);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= ls.valid;
    end
    f_keep       <= ls.keep;
    f_entry.op   <= ls.op;
    f_entry.addr <= {sy[ROW_W-1:0], sx[COL_W-1:0]};
    f_entry.pix  <= ls.pix;
  end

  assign leave   = f_valid;
  assign q_push  = f_valid && f_keep;
  assign q_entry = f_entry;

endmodule

// ===== rtl/ccns_queue.sv =====
// Queue of classified beats between front and back ends
`include "cover_crop_nearest_scaler_unit_assert.svh"
module ccns_queue import ccns_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  entry_t            push_entry,
  input  logic              pop,
  output logic              head_valid,
  output entry_t            head_entry,
  output logic [QCNT_W-1:0] count
);

  entry_t            slots [QDEPTH];
  logic [QPTR_W-1:0] head, tail;

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) tail <= tail + QPTR_W'(1);
      if (pop)  head <= head + QPTR_W'(1);
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[tail] <= push_entry;
  end

  assign head_valid = (count != '0);
  assign head_entry = slots[head];

  `CCNS_ASSERT_IMPLY(a_no_overflow, clk, rst, push, count < QCNT_W'(QDEPTH))
  `CCNS_ASSERT_IMPLY(a_no_underflow, clk, rst, pop, count != '0)

endmodule

// ===== rtl/ccns_back.sv =====
// Back end: frame memory and result buffer
`include "cover_crop_nearest_scaler_unit_assert.svh"
module ccns_back import ccns_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  entry_t           q_entry,
  output logic             q_pop,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [PIX_W-1:0] m_tdata,
  output logic             m_tuser
);

  localparam int ODEPTH = 4;
  localparam int OPTR_W = $clog2(ODEPTH);
  localparam int OCNT_W = $clog2(ODEPTH + 1);

  typedef struct packed {
    logic             oor;
    logic [PIX_W-1:0] pix;
  } result_t;

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rdata;
  logic             rd_valid, rd_oor;

  logic              is_write;
  logic [OCNT_W:0]   busy;
  logic [OCNT_W-1:0] ocount;
  logic [OPTR_W-1:0] ohead, otail;
  result_t           obuf [ODEPTH];
  logic              opush, opop;

  assign is_write = (q_entry.op == OP_WRITE);
  assign busy     = {1'b0, ocount} + (OCNT_W+1)'(rd_valid);
  assign q_pop    = q_valid && (is_write || busy < (OCNT_W+1)'(ODEPTH));

  always_ff @(posedge clk) begin
    if (q_pop && is_write) mem[q_entry.addr] <= q_entry.pix;
    if (q_pop && q_entry.op == OP_READ) rdata <= mem[q_entry.addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= q_pop && !is_write;
    end
    rd_oor <= (q_entry.op == OP_RANGE);
  end

  assign opush = rd_valid;
  assign opop  = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ohead  <= '0;
      otail  <= '0;
      ocount <= '0;
    end else begin
      if (opush) otail <= otail + OPTR_W'(1);
      if (opop)  ohead <= ohead + OPTR_W'(1);
      ocount <= ocount + OCNT_W'(opush) - OCNT_W'(opop);
    end
  end

  always_ff @(posedge clk) begin
    if (opush) obuf[otail] <= '{oor: rd_oor, pix: rd_oor ? '0 : rdata};
  end

  assign m_tvalid = (ocount != '0);
  assign m_tdata  = obuf[ohead].pix;
  assign m_tuser  = obuf[ohead].oor;

  `CCNS_ASSERT_IMPLY(a_out_no_overflow, clk, rst, opush, ocount < OCNT_W'(ODEPTH))
  `CCNS_ASSERT_NEXT(a_read_lands, clk, rst, q_pop && !is_write, rd_valid)

endmodule

// ===== dv/cover_crop_nearest_scaler_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the cover-crop nearest scaler: directed table, then random phases
module cover_crop_nearest_scaler_unit_tb;
  import ccns_pkg::*;

  typedef enum {ROW_STORE, ROW_FETCH, ROW_CFG} plan_kind_t;

  typedef struct {
    logic [7:0] first;
    logic [7:0] middle;
    logic [7:0] last;
    logic       oor;
  } pixel_out_t;

  typedef struct {
    plan_kind_t what;
    int         a;      // column, or register index
    int         b;      // row, or register value
    logic [7:0] p0, p1, p2;
    bit         typed;
    logic [7:0] e0, e1, e2;
    logic       eoor;
  } plan_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             s_tuser = 1'b0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [PIX_W-1:0] m_tdata;
  logic             m_tuser;
  logic             cfg_wen = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0] cfg_data = '0;

  int unsigned src_w = 256, src_h = 256, tgt_w = 0, tgt_h = 0;
  logic [PIX_W-1:0] frame_pix [0:DEPTH-1];
  bit               frame_seen [0:DEPTH-1];
  pixel_out_t       pending_pixels [$];
  int               errors = 0;
  int               send_idle_pct = 0;
  int               stall_pct = 0;

  cover_crop_nearest_scaler_unit dut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

  always @(negedge clk) begin
    m_tready = ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    pixel_out_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_pixels.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h oor %b", m_tdata, m_tuser);
      end else begin
        want = pending_pixels.pop_front();
        if (m_tdata[7:0] !== want.first || m_tdata[15:8] !== want.middle ||
            m_tdata[23:16] !== want.last || m_tuser !== want.oor) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected %h %h %h oor %b, got %h %h %h oor %b",
                     want.first, want.middle, want.last, want.oor,
                     m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tuser);
        end
      end
    end
  end

  function automatic int unsigned eff_src(int unsigned v);
    return (v < 1) ? 1 : ((v > 256) ? 256 : v);
  endfunction

  function automatic bit no_scaling();
    return (tgt_w == 0 || tgt_h == 0 ||
            (tgt_w == eff_src(src_w) && tgt_h == eff_src(src_h)));
  endfunction

  function automatic longint unsigned cover_axis(longint unsigned t, longint unsigned s,
                                                 longint unsigned tsize, longint unsigned num,
                                                 longint unsigned den);
    longint unsigned base, crop, v;
    base = s * num;
    crop = tsize * den;
    if (crop > base) crop = base;
    v = (base - crop + (2 * t + 1) * den) / (2 * num);
    if (v > s - 1) v = s - 1;
    return v;
  endfunction

  // map a target coordinate onto its source address
  function automatic void locate(input int col, input int row, output bit oor, output int addr);
    longint unsigned sw, sh, tw, th, num, den, sx, sy;
    bit ident;
    sw = eff_src(src_w);
    sh = eff_src(src_h);
    tw = tgt_w;
    th = tgt_h;
    ident = no_scaling();
    if (ident) begin
      tw = sw;
      th = sh;
    end
    oor = (col >= tw || row >= th);
    addr = 0;
    if (!oor) begin
      if (ident) begin
        sx = col;
        sy = row;
      end else begin
        if (tw * sh >= th * sw) begin
          num = tw;
          den = sw;
        end else begin
          num = th;
          den = sh;
        end
        sx = cover_axis(col, sw, tw, num, den);
        sy = cover_axis(row, sh, th, num, den);
      end
      addr = int'((sy * MAX_WIDTH + sx) % DEPTH);
    end
  endfunction

  task automatic wait_drained();
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(int idx, int val);
    wait_drained();
    @(negedge clk);
    cfg_wen = 1'b1;
    cfg_index = idx[IDX_W-1:0];
    cfg_data = val[DIM_W-1:0];
    @(negedge clk);
    cfg_wen = 1'b0;
    case (idx[IDX_W-1:0])
      REG_SOURCE_WIDTH:  src_w = val & 'h1FF;
      REG_SOURCE_HEIGHT: src_h = val & 'h1FF;
      REG_DST_WIDTH:     tgt_w = val & 'h1FF;
      REG_DST_HEIGHT:    tgt_h = val & 'h1FF;
      default: ;
    endcase
  endtask

  task automatic drive_beat(bit kind, int col, int row, logic [7:0] p0, logic [7:0] p1,
                            logic [7:0] p2);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = kind;
    s_tdata = {p2, p1, p0, row[7:0], col[7:0]};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic store_pixel(int col, int row, logic [7:0] p0, logic [7:0] p1, logic [7:0] p2);
    drive_beat(1'b0, col, row, p0, p1, p2);
    if (col < eff_src(src_w) && row < eff_src(src_h)) begin
      frame_pix[row * MAX_WIDTH + col] = {p0, p1, p2};
      frame_seen[row * MAX_WIDTH + col] = 1'b1;
    end
  endtask

  task automatic fetch_pixel(int col, int row, bit typed, pixel_out_t typed_res);
    bit oor;
    int addr;
    pixel_out_t want;
    locate(col, row, oor, addr);
    // fill an unwritten source entry before it is read
    if (!oor && !frame_seen[addr])
      store_pixel(addr % MAX_WIDTH, addr / MAX_WIDTH, 8'($urandom), 8'($urandom),
                  8'($urandom));
    drive_beat(1'b1, col, row, 8'($urandom), 8'($urandom), 8'($urandom));
    if (typed) begin
      want = typed_res;
    end else if (oor) begin
      want = '{8'h00, 8'h00, 8'h00, 1'b1};
    end else begin
      want = '{frame_pix[addr][7:0], frame_pix[addr][15:8], frame_pix[addr][23:16], 1'b0};
    end
    pending_pixels.push_back(want);
  endtask

  function automatic int pick_src();
    case ($urandom_range(9))
      0: return 1;
      1: return 256;
      2: return 0;
      3: return $urandom_range(257, 511);
      4: return $urandom_range(1, 256);
      default: return $urandom_range(1, 16);
    endcase
  endfunction

  function automatic int pick_tgt();
    case ($urandom_range(9))
      0: return 0;
      1: return 256;
      2: return 511;
      3: return $urandom_range(1, 256);
      default: return $urandom_range(1, 32);
    endcase
  endfunction

  plan_row_t plan [] = '{
    '{ROW_STORE, 0, 0, 8'hAA, 8'hBB, 8'hCC, 0, 0, 0, 0, 0},
    '{ROW_FETCH, 0, 0, 0, 0, 0, 1, 8'hCC, 8'hBB, 8'hAA, 0},
    '{ROW_STORE, 255, 255, 8'h01, 8'h80, 8'hFE, 0, 0, 0, 0, 0},
    '{ROW_FETCH, 255, 255, 0, 0, 0, 1, 8'hFE, 8'h80, 8'h01, 0},
    '{ROW_STORE, 255, 0, 8'h00, 8'h00, 8'h00, 0, 0, 0, 0, 0},
    '{ROW_FETCH, 255, 0, 0, 0, 0, 1, 8'h00, 8'h00, 8'h00, 0},
    '{ROW_STORE, 0, 255, 8'hFF, 8'hFF, 8'hFF, 0, 0, 0, 0, 0},
    '{ROW_FETCH, 0, 255, 0, 0, 0, 1, 8'hFF, 8'hFF, 8'hFF, 0},
    '{ROW_CFG, REG_SOURCE_WIDTH, 4, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_CFG, REG_SOURCE_HEIGHT, 4, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_STORE, 4, 0, 8'h55, 8'h55, 8'h55, 0, 0, 0, 0, 0},
    '{ROW_STORE, 3, 3, 8'h12, 8'h34, 8'h56, 0, 0, 0, 0, 0},
    '{ROW_FETCH, 3, 3, 0, 0, 0, 1, 8'h56, 8'h34, 8'h12, 0},
    '{ROW_FETCH, 4, 0, 0, 0, 0, 1, 8'h00, 8'h00, 8'h00, 1},
    '{ROW_FETCH, 0, 4, 0, 0, 0, 1, 8'h00, 8'h00, 8'h00, 1},
    '{ROW_CFG, REG_DST_WIDTH, 4, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_CFG, REG_DST_HEIGHT, 4, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_FETCH, 3, 3, 0, 0, 0, 1, 8'h56, 8'h34, 8'h12, 0},
    '{ROW_CFG, REG_DST_WIDTH, 8, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_CFG, REG_DST_HEIGHT, 8, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_FETCH, 7, 7, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_FETCH, 8, 0, 0, 0, 0, 1, 8'h00, 8'h00, 8'h00, 1},
    '{ROW_CFG, REG_SOURCE_WIDTH, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_CFG, REG_SOURCE_HEIGHT, 511, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_FETCH, 5, 7, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_CFG, REG_DST_WIDTH, 511, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_CFG, REG_DST_HEIGHT, 5, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_FETCH, 255, 4, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_FETCH, 0, 5, 0, 0, 0, 1, 8'h00, 8'h00, 8'h00, 1}
  };

  initial begin
    int span_w, span_h;
    bit ident;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) begin
      case (plan[i].what)
        ROW_STORE: store_pixel(plan[i].a, plan[i].b, plan[i].p0, plan[i].p1, plan[i].p2);
        ROW_FETCH: fetch_pixel(plan[i].a, plan[i].b, plan[i].typed,
                               '{plan[i].e0, plan[i].e1, plan[i].e2, plan[i].eoor});
        default: begin
          @(negedge clk);
          s_tvalid = 1'b0;
          write_reg(plan[i].a, plan[i].b);
        end
      endcase
    end

    for (int ph = 0; ph < 8; ph++) begin
      @(negedge clk);
      s_tvalid = 1'b0;
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 53; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 53; end
        default: begin send_idle_pct = 19; stall_pct = 19; end
      endcase
      write_reg(REG_SOURCE_WIDTH, (ph == 0) ? 256 : pick_src());
      write_reg(REG_SOURCE_HEIGHT, (ph == 0) ? 256 : pick_src());
      write_reg(REG_DST_WIDTH, (ph == 0) ? 0 : pick_tgt());
      write_reg(REG_DST_HEIGHT, (ph == 0) ? 0 : pick_tgt());
      ident = no_scaling();
      span_w = ident ? eff_src(src_w) : tgt_w;
      span_h = ident ? eff_src(src_h) : tgt_h;
      if (span_w > 256) span_w = 256;
      if (span_h > 256) span_h = 256;
      for (int n = 0; n < 180; n++) begin
        if ($urandom_range(99) < 40) begin
          if ($urandom_range(99) < 85)
            store_pixel($urandom_range(eff_src(src_w) - 1), $urandom_range(eff_src(src_h) - 1),
                        8'($urandom), 8'($urandom), 8'($urandom));
          else
            store_pixel($urandom_range(255), $urandom_range(255),
                        8'($urandom), 8'($urandom), 8'($urandom));
        end else begin
          if ($urandom_range(99) < 85 && span_w > 0 && span_h > 0)
            fetch_pixel($urandom_range(span_w - 1), $urandom_range(span_h - 1), 0, '{0, 0, 0, 0});
          else
            fetch_pixel($urandom_range(255), $urandom_range(255), 0, '{0, 0, 0, 0});
        end
      end
    end

    @(negedge clk);
    s_tvalid = 1'b0;
    wait_drained();
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ccns_pkg.sv
rtl/ccns_div.sv
rtl/ccns_front.sv
rtl/ccns_queue.sv
rtl/ccns_back.sv
rtl/cover_crop_nearest_scaler_unit.sv
dv/cover_crop_nearest_scaler_unit_tb.sv
